### design/f2m_pkg.sv
// ----------------------------------------------------------------------------
// f2m_pkg: shared types and constants for the fp32 to 10-bit minifloat path
// Holds the stage payload types and the format constants.
// ----------------------------------------------------------------------------
package f2m_pkg;

    localparam logic [9:0]  MINI_INF     = 10'h1F0;
    localparam logic [9:0]  MINI_NAN     = 10'h1FF;
    localparam logic [7:0]  EXP_NORM_MIN = 8'd113;
    localparam logic [7:0]  EXP_OVF_MAX  = 8'd142;
    localparam logic [7:0]  EXP_BIAS_ADJ = 8'd112;

    // decode stage -> align stage
    typedef struct packed {
        logic        sgn;
        logic        is_nan;
        logic        is_ovf;
        logic        is_sub;
        logic [4:0]  sh;      // subnormal shift, saturated at 31
        logic [4:0]  ex_field;
        logic [23:0] sig;
    } t_dec;

    // align stage -> round stage
    typedef struct packed {
        logic        sgn;
        logic        is_nan;
        logic        is_ovf;
        logic [4:0]  ex_field;
        logic [23:0] body;
        logic        sticky;
    } t_aln;

endpackage

### design/f2m_decode.sv
// ----------------------------------------------------------------------------
// f2m_decode: first stage
// Split the single fields, classify, and work out the subnormal shift.
// ----------------------------------------------------------------------------
module f2m_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [31:0]       i_single_bits,
    output logic              o_valid,
    output f2m_pkg::t_dec     o_dec
);
    import f2m_pkg::*;

    logic        r_valid;
    t_dec        r_dec;
    t_dec        n_dec;
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [7:0]  e1;
    logic [7:0]  sh_full;

    always_comb begin
        bexp           = i_single_bits[30:23];
        frac           = i_single_bits[22:0];
        e1             = (bexp == 8'd0) ? 8'd1 : bexp;
        sh_full        = EXP_NORM_MIN - e1;
        n_dec.sgn      = i_single_bits[31];
        n_dec.is_nan   = (bexp == 8'hFF) && (frac != 23'd0);
        n_dec.is_ovf   = bexp > EXP_OVF_MAX;
        n_dec.is_sub   = bexp < EXP_NORM_MIN;
        n_dec.sh       = (sh_full > 8'd31) ? 5'd31 : sh_full[4:0];
        n_dec.ex_field = n_dec.is_sub ? 5'd0 : 5'(bexp - EXP_BIAS_ADJ);
        n_dec.sig      = {bexp != 8'd0, frac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

### design/f2m_align.sv
// ----------------------------------------------------------------------------
// f2m_align: second stage
// Shift subnormal significands right and collect sticky.
// ----------------------------------------------------------------------------
module f2m_align (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  f2m_pkg::t_dec     i_dec,
    output logic              o_valid,
    output f2m_pkg::t_aln     o_aln
);
    import f2m_pkg::*;

    logic        r_valid;
    t_aln        r_aln;
    t_aln        n_aln;
    logic [23:0] mask;

    always_comb begin
        mask           = 24'(({32'd0, 1'b1} << i_dec.sh) - 33'd1);
        if (i_dec.sh > 5'd23) begin
            mask = '1;
        end
        n_aln.sgn      = i_dec.sgn;
        n_aln.is_nan   = i_dec.is_nan;
        n_aln.is_ovf   = i_dec.is_ovf;
        n_aln.ex_field = i_dec.ex_field;
        if (i_dec.is_sub) begin
            n_aln.body   = i_dec.sig >> i_dec.sh;
            n_aln.sticky = (i_dec.sig & mask) != 24'd0;
        end else begin
            n_aln.body   = {1'b0, i_dec.sig[22:0]};
            n_aln.sticky = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_aln <= n_aln;
    end

    assign o_valid = r_valid;
    assign o_aln   = r_aln;
endmodule

### design/f2m_round.sv
// ----------------------------------------------------------------------------
// f2m_round: third stage
// Round to nearest even, saturate to infinity, apply NaN and sign.
// ----------------------------------------------------------------------------
module f2m_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  f2m_pkg::t_aln     i_aln,
    output logic              o_valid,
    output logic [9:0]        o_mini_bits
);
    import f2m_pkg::*;

    logic       r_valid;
    logic [9:0] r_mini;
    logic [9:0] n_mini;
    logic [9:0] field;
    logic       up;

    always_comb begin
        field = {1'b0, i_aln.ex_field, i_aln.body[22:19]};
        up    = i_aln.body[18] && ((i_aln.body[19:0] & 20'hBFFFF) != 20'd0 || i_aln.sticky);
        field = field + {9'd0, up};
        if (field >= MINI_INF) begin
            field = MINI_INF;
        end
        if (i_aln.is_nan) begin
            field = MINI_NAN;
        end else if (i_aln.is_ovf) begin
            field = MINI_INF;
        end
        n_mini = field | {i_aln.sgn, 9'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_mini <= n_mini;
    end

    assign o_valid     = r_valid;
    assign o_mini_bits = r_mini;
endmodule

### design/fp32_to_fp10_convert.sv
// Throughput one word per cycle.
// Three register stages: decode, align (subnormal shift), round.
// busy is held low: a new word enters on every start.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
// The receiver cannot stall; o_done marks each result for one cycle.
// ----------------------------------------------------------------------------
// fp32_to_fp10_convert: single precision to 1-5-4 minifloat converter
// Three-stage pipeline, round to nearest even, signed inf and NaN kept.
// ----------------------------------------------------------------------------
module fp32_to_fp10_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_single_bits,
    output logic        o_done,
    output logic [9:0]  o_mini_bits
);
    import f2m_pkg::*;

    logic v1;
    logic v2;
    t_dec dec;
    t_aln aln;

    // never stall: every stage advances each cycle
    assign busy = 1'b0;

    f2m_decode u_dec (
        .i_clk, .i_rst_n, .i_valid(start), .i_single_bits,
        .o_valid(v1), .o_dec(dec)
    );

    f2m_align u_aln (
        .i_clk, .i_rst_n, .i_valid(v1), .i_dec(dec),
        .o_valid(v2), .o_aln(aln)
    );

    f2m_round u_rnd (
        .i_clk, .i_rst_n, .i_valid(v2), .i_aln(aln),
        .o_valid(o_done), .o_mini_bits
    );
endmodule

### tb/sv/fp32_to_fp10_convert_test.sv
// ----------------------------------------------------------------------------
// fp32_to_fp10_convert_test: self-checking bench for the minifloat converter
// Sends directed and random single-precision words, predicts each 10-bit
// result in the bench and compares every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module fp32_to_fp10_convert_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_single_bits;
    logic        o_done;
    logic [9:0]  o_mini_bits;

    logic [9:0]  mini_expected[$];
    int          err_count;
    int          words_sent;
    int          words_checked;

    fp32_to_fp10_convert u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_single_bits (i_single_bits),
        .o_done        (o_done),
        .o_mini_bits   (o_mini_bits)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Compute the rounded minifloat for one single-precision pattern.
    function automatic logic [9:0] fp32_to_mini(input logic [31:0] bits);
        logic        sgn;
        logic [7:0]  bexp;
        logic [22:0] frac;
        logic [23:0] sig;
        logic [23:0] body;
        logic [31:0] field;
        logic [4:0]  ex_field;
        logic        sticky;
        logic        up;
        int          sh;
        logic [9:0]  res;
        sgn  = bits[31];
        bexp = bits[30:23];
        frac = bits[22:0];
        sticky = 1'b0;
        if (bexp == 8'hFF && frac != 0) begin
            res = f2m_pkg::MINI_NAN;
        end else if (bexp > f2m_pkg::EXP_OVF_MAX) begin
            res = f2m_pkg::MINI_INF;
        end else begin
            if (bexp >= f2m_pkg::EXP_NORM_MIN) begin
                body     = {1'b0, frac};
                ex_field = 5'(bexp - f2m_pkg::EXP_BIAS_ADJ);
            end else begin
                // subnormal input acts as exponent 1 with no hidden bit
                sig = {(bexp != 0), frac};
                sh  = 113 - ((bexp == 0) ? 1 : int'(bexp));
                if (sh > 31) sh = 31;
                sticky   = (sh >= 24) ? (sig != 0) : ((sig & ((24'd1 << sh) - 1)) != 0);
                body     = (sh >= 24) ? 24'd0 : (sig >> sh);
                ex_field = 5'd0;
            end
            field = {23'd0, ex_field, body[22:19]};
            up    = body[18] && ((body & 24'h0BFFFF) != 0 || sticky);
            if (up) field = field + 1;
            if (field >= 32'(f2m_pkg::MINI_INF)) field = 32'(f2m_pkg::MINI_INF);
            res = field[9:0];
        end
        return res | {sgn, 9'd0};
    endfunction

    // Send one word: drop start for the gap, then hold it until accepted.
    task automatic send_word(input logic [31:0] bits, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_single_bits <= bits;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        mini_expected.push_back(fp32_to_mini(bits));
        words_sent++;
    endtask

    // Check each strobed result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (mini_expected.size() == 0) begin
                $error("mini_bits: unexpected result, expected none, actual %h", o_mini_bits);
                err_count++;
            end else begin
                logic [9:0] want;
                want = mini_expected.pop_front();
                words_checked++;
                if (o_mini_bits !== want) begin
                    $error("mini_bits: expected %h, actual %h", want, o_mini_bits);
                    err_count++;
                end
            end
        end
    end

    function automatic int draw_gap();
        // about a third of words go back to back
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic test_directed();
        logic [31:0] vals[$];
        vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFF80_0001, 32'h7FFF_FFFF, 32'h4780_0000,
                 32'h477F_FFFF, 32'h4778_0000, 32'h4774_0000, 32'h3880_0000,
                 32'h3800_0000, 32'h387F_FFFF, 32'h3300_0000, 32'h2F80_0001,
                 32'h0000_0001, 32'h807F_FFFF, 32'h3F84_0000, 32'h3F8C_0000,
                 32'h3F84_0001, 32'h3F80_0000, 32'hBF80_0000, 32'hFFFF_FFFF};
        foreach (vals[i]) send_word(vals[i], 0);
    endtask

    task automatic test_random(input int count);
        logic [31:0] v;
        for (int i = 0; i < count; i++) begin
            v = $urandom();
            case ($urandom_range(0, 3))
                // steer half of the words into the interesting exponent window
                0: v[30:23] = 8'($urandom_range(100, 145));
                1: v[30:23] = 8'($urandom_range(110, 115));
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0) v[17:0] = 18'd0;
            send_word(v, draw_gap());
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (mini_expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        err_count = 0;
        words_sent = 0;
        words_checked = 0;
        start = 1'b0;
        i_single_bits = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain_results();  // pause the sender until every result is in
        test_random(325);
        drain_results();
        test_random(325);
        drain_results();
        $display("Covered %0d words, %0d results checked (directed specials plus random).",
                 words_sent, words_checked);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
